### design/gqc_pkg.sv
// shared types, widths and action codes for the gated quadrature counter
package gqc_pkg;

    localparam int ACTION_W = 2;
    localparam int COUNT_W  = 32;
    localparam int WHOLE_W  = COUNT_W - 2;

    localparam logic [ACTION_W-1:0] ACT_EDGE_A     = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_EDGE_B     = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_PIN_CHANGE = 2'd2;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic                level_a;
        logic                level_b;
        logic                tape_present;
        logic                reset_button;
    } t_item;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic               enable;
    } t_state;

endpackage

### design/gqc_step.sv
// next count and enable flag for one event
module gqc_step (
    input  gqc_pkg::t_item  i_item,
    input  gqc_pkg::t_state i_state,
    output gqc_pkg::t_state o_state
);
    import gqc_pkg::*;

    logic               up;
    logic [COUNT_W-1:0] stepped;
    logic [COUNT_W-1:0] truncated;
    logic [1:0]         neg_low;

    always_comb begin
        // odd counts go up on A and down on B
        up      = (i_item.action == ACT_EDGE_A) ? i_state.count[0] : ~i_state.count[0];
        stepped = i_state.count + {{(COUNT_W-1){~up}}, 1'b1};

        // truncate toward zero: negative values add the low bits of their magnitude
        neg_low = (~i_state.count[1:0]) + 2'b01;
        if (i_state.count[COUNT_W-1]) begin
            truncated = i_state.count + {{(COUNT_W-2){1'b0}}, neg_low};
        end else begin
            truncated = {i_state.count[COUNT_W-1:2], 2'b00};
        end

        o_state = i_state;
        case (i_item.action)
            ACT_EDGE_A, ACT_EDGE_B: begin
                if (i_item.tape_present &&
                    (i_state.enable || (i_item.level_a && i_item.level_b))) begin
                    o_state.enable = 1'b1;
                    o_state.count  = stepped;
                end
            end
            ACT_PIN_CHANGE: begin
                if (!i_item.tape_present) begin
                    o_state.enable = 1'b0;
                    o_state.count  = truncated;
                end
                if (i_item.reset_button) begin
                    o_state.count = '0;
                end
            end
            default: begin
                o_state = i_state;
            end
        endcase
    end

endmodule

### design/gated_quadrature_counter_top.sv
// top level of the gated x4 quadrature counter
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+---------------------------------------------
//  event   | in        | i_valid / o_ready  | i_action, i_level_a, i_level_b,
//          |           |                    | i_tape_present, i_reset_button
//  result  | out       | o_valid / i_ready  | o_step_count, o_whole_steps, o_counting_on
//
// one event per cycle while the result is not stalled
// the event is held in an input register, the count and flag registers double as the
// result register, so the state after each event is what the result shows
// a stalled result holds the state; one more event waits in the input register
// synchronous active-low reset clears the count, the enable flag and both valid bits
module gated_quadrature_counter_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [gqc_pkg::ACTION_W-1:0]       i_action,
    input  logic                               i_level_a,
    input  logic                               i_level_b,
    input  logic                               i_tape_present,
    input  logic                               i_reset_button,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic signed [gqc_pkg::COUNT_W-1:0] o_step_count,
    output logic [gqc_pkg::WHOLE_W-1:0]        o_whole_steps,
    output logic                               o_counting_on
);
    import gqc_pkg::*;

    logic               r_in_valid;
    t_item              r_item;
    logic               r_out_valid;
    logic [COUNT_W-1:0] r_count;
    logic               r_enable;

    t_state             cur_state;
    t_state             n_state;
    logic               advance;
    logic [COUNT_W-1:0] magnitude;

    assign cur_state = '{count: r_count, enable: r_enable};
    assign advance   = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready   = !r_in_valid || advance;

    gqc_step u_step (
        .i_item  (r_item),
        .i_state (cur_state),
        .o_state (n_state)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_count     <= '0;
            r_enable    <= 1'b0;
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_count     <= n_state.count;
                r_enable    <= n_state.enable;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= '{action: i_action, level_a: i_level_a, level_b: i_level_b,
                        tape_present: i_tape_present, reset_button: i_reset_button};
        end
    end

    // magnitude of the most negative count is 2^31, which still fits after the shift
    assign magnitude     = r_count[COUNT_W-1] ? (~r_count + {{(COUNT_W-1){1'b0}}, 1'b1})
                                              : r_count;
    assign o_valid       = r_out_valid;
    assign o_step_count  = signed'(r_count);
    assign o_whole_steps = magnitude[COUNT_W-1:2];
    assign o_counting_on = r_enable;

    a_enable_rises_on_edge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_enable) |-> $past(advance && r_item.tape_present &&
            (r_item.action == ACT_EDGE_A || r_item.action == ACT_EDGE_B)))
        else $error("enable flag set without a counted edge");

    a_blocked_edge_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && !r_enable && !(r_item.level_a && r_item.level_b) &&
        (r_item.action == ACT_EDGE_A || r_item.action == ACT_EDGE_B)
        |=> $stable(r_count))
        else $error("count moved on an edge while counting was disabled");

    a_tape_out_truncates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_item.action == ACT_PIN_CHANGE && !r_item.tape_present
        |=> r_count[1:0] == 2'b00 && !r_enable)
        else $error("count not truncated to a whole step when tape left");

    a_button_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_item.action == ACT_PIN_CHANGE && r_item.reset_button
        |=> r_count == '0)
        else $error("reset button did not clear the count");

    a_state_held_in_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_ready |=> $stable(r_count) && $stable(r_enable))
        else $error("state changed while its result was stalled");

endmodule

### dv/tb.sv
// testbench for the gated x4 quadrature counter: directed table, then random encoder motion
`timescale 1ns / 100ps

module tb;
    import gqc_pkg::*;

    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
    localparam int STALL_LIMIT = 2000;
    localparam int MOTION_TARGET = 1100;
    localparam int DIR_ROWS = 24;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic [WHOLE_W-1:0] whole;
        logic               on;
    } t_result;

    typedef struct packed {
        t_item   ev;
        logic    typed;
        t_result want;
    } t_row;

    localparam t_result CLEARED     = '{32'h0000_0000, 30'h0, 1'b0};
    localparam t_result ARMED_CLEAR = '{32'h0000_0000, 30'h0, 1'b1};
    localparam t_result MINUS_ONE   = '{32'hFFFF_FFFF, 30'h0, 1'b1};

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_ready;
    logic [ACTION_W-1:0]  i_action = ACT_EDGE_A;
    logic                 i_level_a = 1'b0;
    logic                 i_level_b = 1'b0;
    logic                 i_tape_present = 1'b0;
    logic                 i_reset_button = 1'b0;
    logic                 o_valid;
    logic                 i_ready = 1'b0;
    logic signed [COUNT_W-1:0] o_step_count;
    logic [WHOLE_W-1:0]   o_whole_steps;
    logic                 o_counting_on;

    // predictor state
    logic [COUNT_W-1:0] model_count = '0;
    logic               model_on = 1'b0;

    t_result counts_due[$];
    t_result last_shown = CLEARED;
    int      moving_events = 0;
    int      errors = 0;
    int      stall_cycles = 0;
    logic    quiet_stretch = 1'b0;
    logic    pin_a = 1'b0;
    logic    pin_b = 1'b0;

    // directed rows: typed expectations only where they are obvious
    t_row dir_rows [DIR_ROWS] = '{
        '{'{ACT_EDGE_A,     1'b1, 1'b0, 1'b1, 1'b0}, 1'b1, CLEARED},     // gated off
        '{'{ACT_EDGE_B,     1'b1, 1'b1, 1'b0, 1'b0}, 1'b1, CLEARED},     // no tape
        '{'{ACT_PIN_CHANGE, 1'b0, 1'b0, 1'b1, 1'b0}, 1'b1, CLEARED},
        '{'{ACT_UNUSED,     1'b1, 1'b1, 1'b1, 1'b1}, 1'b1, CLEARED},
        '{'{ACT_EDGE_A,     1'b1, 1'b1, 1'b1, 1'b0}, 1'b1, MINUS_ONE},   // arms, steps down
        '{'{ACT_EDGE_B,     1'b0, 1'b1, 1'b1, 1'b0}, 1'b0, CLEARED},
        '{'{ACT_EDGE_A,     1'b0, 1'b0, 1'b1, 1'b0}, 1'b0, CLEARED},
        '{'{ACT_EDGE_B,     1'b0, 1'b1, 1'b1, 1'b0}, 1'b0, CLEARED},
        '{'{ACT_EDGE_A,     1'b1, 1'b1, 1'b1, 1'b0}, 1'b0, CLEARED},
        '{'{ACT_PIN_CHANGE, 1'b1, 1'b1, 1'b0, 1'b0}, 1'b0, CLEARED},     // -5 truncates to -4
        '{'{ACT_EDGE_A,     1'b1, 1'b0, 1'b1, 1'b0}, 1'b0, CLEARED},
        '{'{ACT_EDGE_A,     1'b1, 1'b1, 1'b1, 1'b0}, 1'b0, CLEARED},
        '{'{ACT_EDGE_B,     1'b1, 1'b0, 1'b1, 1'b1}, 1'b0, CLEARED},     // button ignored on edge
        '{'{ACT_UNUSED,     1'b0, 1'b0, 1'b0, 1'b1}, 1'b0, CLEARED},
        '{'{ACT_PIN_CHANGE, 1'b1, 1'b0, 1'b1, 1'b1}, 1'b1, ARMED_CLEAR},
        '{'{ACT_EDGE_B,     1'b0, 1'b0, 1'b1, 1'b0}, 1'b0, CLEARED},
        '{'{ACT_EDGE_A,     1'b1, 1'b0, 1'b1, 1'b0}, 1'b0, CLEARED},
        '{'{ACT_EDGE_B,     1'b1, 1'b1, 1'b1, 1'b0}, 1'b0, CLEARED},
        '{'{ACT_EDGE_A,     1'b0, 1'b1, 1'b1, 1'b0}, 1'b0, CLEARED},
        '{'{ACT_EDGE_B,     1'b0, 1'b0, 1'b1, 1'b0}, 1'b0, CLEARED},
        '{'{ACT_EDGE_A,     1'b1, 1'b0, 1'b0, 1'b0}, 1'b0, CLEARED},     // enabled, tape gone
        '{'{ACT_PIN_CHANGE, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b0, CLEARED},
        '{'{ACT_PIN_CHANGE, 1'b1, 1'b1, 1'b0, 1'b1}, 1'b1, CLEARED},
        '{'{ACT_EDGE_B,     1'b1, 1'b1, 1'b1, 1'b1}, 1'b0, CLEARED}
    };

    gated_quadrature_counter_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_action       (i_action),
        .i_level_a      (i_level_a),
        .i_level_b      (i_level_b),
        .i_tape_present (i_tape_present),
        .i_reset_button (i_reset_button),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_step_count   (o_step_count),
        .o_whole_steps  (o_whole_steps),
        .o_counting_on  (o_counting_on)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic t_result advance_counter(input t_item ev);
        t_result r;
        logic    up;
        logic [COUNT_W-1:0] mag;
        if (ev.action == ACT_EDGE_A || ev.action == ACT_EDGE_B) begin
            if (ev.tape_present && (model_on || (ev.level_a && ev.level_b))) begin
                // x4 direction from count parity
                up = (ev.action == ACT_EDGE_A) ? model_count[0] : !model_count[0];
                model_on = 1'b1;
                model_count = up ? model_count + 32'd1 : model_count - 32'd1;
            end
        end else if (ev.action == ACT_PIN_CHANGE) begin
            if (!ev.tape_present) begin
                model_on = 1'b0;
                mag = model_count[COUNT_W-1] ? -model_count : model_count;
                // truncate toward zero to a multiple of four
                model_count = model_count[COUNT_W-1] ? model_count + {30'h0, mag[1:0]}
                                                     : {model_count[COUNT_W-1:2], 2'b00};
            end
            if (ev.reset_button) begin
                model_count = '0;
            end
        end
        mag = model_count[COUNT_W-1] ? -model_count : model_count;
        r.count = model_count;
        r.whole = mag[COUNT_W-1:2];
        r.on = model_on;
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        if (errors < 40) begin
            $display("tb: mismatch at %0t: %s", $time, msg);
        end
        errors++;
    endtask

    // drives one event until its transfer, then queues the expected result
    task automatic send_event(input t_item ev, input logic use_want, input t_result want);
        t_result r;
        while (!quiet_stretch && $urandom_range(99) < 8) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_action <= ev.action;
        i_level_a <= ev.level_a;
        i_level_b <= ev.level_b;
        i_tape_present <= ev.tape_present;
        i_reset_button <= ev.reset_button;
        @(posedge i_clk);
        while (o_ready !== 1'b1) @(posedge i_clk);
        r = advance_counter(ev);
        counts_due.push_back(use_want ? want : r);
        if (r != last_shown) moving_events++;
        last_shown = r;
    endtask

    task automatic hold_until_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (counts_due.size() != 0) @(posedge i_clk);
    endtask

    // a run of encoder edges, mostly alternating channels, with the odd reversal
    task automatic drive_motion_burst();
        t_item ev;
        int    steps;
        logic  on_b;
        steps = ($urandom_range(19) == 0) ? $urandom_range(300, 100) : $urandom_range(40, 2);
        on_b = 1'($urandom_range(1));
        if ($urandom_range(1)) begin
            pin_a = 1'b1;
            pin_b = 1'b1;
            ev = '{on_b ? ACT_EDGE_B : ACT_EDGE_A, 1'b1, 1'b1, 1'b1, 1'(($urandom_range(1)))};
            send_event(ev, 1'b0, CLEARED);
        end
        repeat (steps) begin
            if ($urandom_range(99) < 88) on_b = !on_b;
            if (on_b) pin_b = !pin_b;
            else pin_a = !pin_a;
            ev.action = on_b ? ACT_EDGE_B : ACT_EDGE_A;
            ev.level_a = pin_a;
            ev.level_b = pin_b;
            ev.tape_present = ($urandom_range(99) >= 3);
            ev.reset_button = 1'($urandom_range(1));
            send_event(ev, 1'b0, CLEARED);
        end
        if ($urandom_range(99) < 40) begin
            ev.action = ACT_PIN_CHANGE;
            ev.level_a = pin_a;
            ev.level_b = pin_b;
            ev.tape_present = ($urandom_range(99) < 25);
            ev.reset_button = ($urandom_range(99) < 30);
            send_event(ev, 1'b0, CLEARED);
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_result want;
        i_ready <= quiet_stretch || ($urandom_range(99) >= 8);
        if (i_rst_n && o_valid && i_ready) begin
            if (counts_due.size() == 0) begin
                report_mismatch("result transfer with nothing pending");
            end else begin
                want = counts_due.pop_front();
                if (o_step_count !== want.count)
                    report_mismatch($sformatf("step_count got %0d want %0d",
                                              o_step_count, $signed(want.count)));
                if (o_whole_steps !== want.whole)
                    report_mismatch($sformatf("whole_steps got %0d want %0d",
                                              o_whole_steps, want.whole));
                if (o_counting_on !== want.on)
                    report_mismatch($sformatf("counting_on got %b want %b",
                                              o_counting_on, want.on));
            end
        end
    end

    // ends the run when no transfer happens for too long
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles + 1 >= STALL_LIMIT) begin
            $display("tb: done, errors");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        t_item ev;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < DIR_ROWS; i++) begin
            send_event(dir_rows[i].ev, dir_rows[i].typed, dir_rows[i].want);
        end
        hold_until_drained();

        moving_events = 0;
        while (moving_events < MOTION_TARGET) begin
            quiet_stretch <= (moving_events >= 450 && moving_events < 700);
            if ($urandom_range(99) < 10) begin
                repeat ($urandom_range(3, 1)) begin
                    ev.action = ACTION_W'($urandom_range(3));
                    ev.level_a = 1'($urandom_range(1));
                    ev.level_b = 1'($urandom_range(1));
                    ev.tape_present = 1'($urandom_range(1));
                    ev.reset_button = 1'($urandom_range(1));
                    send_event(ev, 1'b0, CLEARED);
                end
            end else begin
                drive_motion_burst();
            end
            if ($urandom_range(29) == 0) hold_until_drained();
        end

        i_valid <= 1'b0;
        while (counts_due.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (errors == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule
